>>> hdl/gb_pkg.sv
// ----------------------------------------------------------------------------
// gb_pkg
// Shared constants, types and register codes of the 3x3 RGB Gaussian blur.
// ----------------------------------------------------------------------------
package gb_pkg;

    // frame geometry
    localparam int MAX_WIDTH = 2048;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W     = 12;
    localparam int COL_W     = 11;
    localparam int DIM_W     = 12;

    // pixel layout: channel k at bits 8k+7..8k (blue, green, red)
    localparam int CHANNELS  = 3;
    localparam int CHAN_W    = 8;
    localparam int PIX_W     = CHANNELS * CHAN_W;
    localparam int SUM_W     = CHAN_W + 4;
    localparam int TAPS      = 9;

    // results caused by one input word
    localparam int MAX_RES   = 4;
    localparam int RES_IDX_W = $clog2(MAX_RES);
    localparam int RES_CNT_W = RES_IDX_W + 1;

    // configuration registers
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [DIM_W-1:0]     WIDTH_RESET      = 12'd640;
    localparam logic [DIM_W-1:0]     HEIGHT_RESET     = 12'd480;
    localparam logic [DIM_W-1:0]     DIM_MIN          = 12'd3;
    localparam logic [DIM_W-1:0]     DIM_MAX_WIDTH    = DIM_W'(MAX_WIDTH);

    typedef logic [PIX_W-1:0] t_pix;

    // taps of one channel, window order: upper, middle, lower row, each left column, center column, new column
    typedef logic [TAPS-1:0][CHAN_W-1:0] t_taps;

    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        t_pix             pix;
    } t_res;

    typedef t_res [MAX_RES-1:0] t_res_set;

    // position flags of the word in the pipeline stage
    typedef struct packed {
        logic r_ge1;
        logic r_ge2;
        logic c_ge1;
        logic c_ge2;
        logic last_col;
        logic last_row;
    } t_pos;

endpackage

>>> hdl/gb_line_buf.sv
// ----------------------------------------------------------------------------
// gb_line_buf
// Two-row line buffer: each entry holds the upper and the middle row pixel
// of one column. One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module gb_line_buf
    import gb_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rd_en,
    input  logic [ADDR_W-1:0]   i_rd_addr,
    output logic [2*PIX_W-1:0]  o_rd_data,
    input  logic                i_wr_en,
    input  logic [ADDR_W-1:0]   i_wr_addr,
    input  logic [2*PIX_W-1:0]  i_wr_data
);

    logic [2*PIX_W-1:0] mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read port, data held while the consumer stalls
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hdl/gb_lane.sv
// ----------------------------------------------------------------------------
// gb_lane
// One channel of the blur: 1-2-1 / 2-4-2 / 1-2-1 weighted sum, divided by 16.
// ----------------------------------------------------------------------------
module gb_lane
    import gb_pkg::*;
(
    input  t_taps              i_taps,
    output logic [CHAN_W-1:0]  o_blur
);

    logic [SUM_W-1:0] corners;
    logic [SUM_W-1:0] edges;
    logic [SUM_W-1:0] sum;

    // corners weight 1, edge centers weight 2, center weight 4
    assign corners = SUM_W'(i_taps[0]) + SUM_W'(i_taps[2])
                   + SUM_W'(i_taps[6]) + SUM_W'(i_taps[8]);
    assign edges   = SUM_W'(i_taps[1]) + SUM_W'(i_taps[3])
                   + SUM_W'(i_taps[5]) + SUM_W'(i_taps[7]);
    assign sum     = corners + (edges << 1) + (SUM_W'(i_taps[4]) << 2);

    // divide by 16, truncating
    assign o_blur  = sum[SUM_W-1:4];

endmodule

>>> hdl/gb_merge.sv
// ----------------------------------------------------------------------------
// gb_merge
// Result buffer: loads the ordered results of one input word and hands
// them out one word per cycle while i_stall is low, flagging the last of the run.
// ----------------------------------------------------------------------------
module gb_merge
    import gb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_load,
    input  t_res_set             i_set,
    input  logic [RES_CNT_W-1:0] i_count,
    output logic                 o_free,
    output logic                 o_valid,
    input  logic                 i_stall,
    output t_res                 o_res,
    output logic                 o_last
);

    t_res_set             r_slot;
    logic [RES_CNT_W-1:0] r_cnt;
    logic [RES_IDX_W-1:0] r_idx;
    logic                 out_acc;

    assign o_valid = (r_cnt != '0);
    assign o_res   = r_slot[r_idx];
    assign o_last  = (RES_CNT_W'(r_idx) + RES_CNT_W'(1)) == r_cnt;
    assign out_acc = o_valid && !i_stall;
    assign o_free  = !o_valid || (out_acc && o_last);

    // payload slots
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_slot <= i_set;
        end
    end

    // fill count and read pointer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_idx <= '0;
        end else if (i_load) begin
            r_cnt <= i_count;
            r_idx <= '0;
        end else if (out_acc) begin
            if (o_last) begin
                r_cnt <= '0;
                r_idx <= '0;
            end else begin
                r_idx <= r_idx + RES_IDX_W'(1);
            end
        end
    end

endmodule

>>> hdl/gaussian_blur_3x3_rgb_top.sv
// An accepted word is registered in the window stage, then its results load into the
// result buffer and show at o_valid. Throughput: one result word per cycle while i_stall
// is low; a word with n results holds the result buffer until all n are taken, so inner
// rows run one pixel per cycle and row ends, the last row and the last pixel wait longer.
// Reset: synchronous; clears counters, window and pipeline, restores 640x480.
// The line buffer is not cleared; stale entries read in the first two rows feed no result.
// ----------------------------------------------------------------------------
// gaussian_blur_3x3_rgb_top
// Raster-order RGB 3x3 Gaussian blur with a two-row line buffer, a 3x3 window,
// one blur lane per channel and a result buffer that orders the outputs.
// ----------------------------------------------------------------------------
module gaussian_blur_3x3_rgb_top
    import gb_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // pixel input
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [CHAN_W-1:0]    i_pixel_blue,
    input  logic [CHAN_W-1:0]    i_pixel_green,
    input  logic [CHAN_W-1:0]    i_pixel_red,
    // result output
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [ROW_W-1:0]     o_out_row,
    output logic [COL_W-1:0]     o_out_col,
    output logic [CHAN_W-1:0]    o_out_blue,
    output logic [CHAN_W-1:0]    o_out_green,
    output logic [CHAN_W-1:0]    o_out_red,
    output logic                 o_last_of_run,
    // configuration writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [DIM_W-1:0]     i_cfg_data
);

    logic [DIM_W-1:0]     r_width;
    logic [DIM_W-1:0]     r_height;
    logic [DIM_W-1:0]     w_eff;
    logic [DIM_W-1:0]     h_eff;
    logic [DIM_W-1:0]     w_last;
    logic [DIM_W-1:0]     h_last;
    logic                 cfg_we;
    logic                 cfg_hit;

    logic [ROW_W-1:0]     r_row;
    logic [COL_W-1:0]     r_col;
    logic [ROW_W-1:0]     n_row;
    logic [COL_W-1:0]     n_col;
    logic                 accept;
    t_pos                 pos;

    logic                 r_b_valid;
    t_pix                 r_b_pix;
    logic [ROW_W-1:0]     r_b_row;
    logic [COL_W-1:0]     r_b_col;
    t_pos                 r_b_pos;
    logic                 b_xfer;

    logic [2*PIX_W-1:0]   mem_q;
    t_pix                 up;
    t_pix                 mid;
    t_pix                 r_win [6];

    t_taps                taps [CHANNELS];
    t_pix                 blur;
    t_res                 cand [MAX_RES];
    logic [MAX_RES-1:0]   cand_v;
    t_res_set             res_set;
    logic [RES_CNT_W-1:0] res_n;

    logic                 buf_free;
    t_res                 out_res;

    // ------------------------------------------------------------------
    // configuration
    // ------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign cfg_hit     = cfg_we && ((i_cfg_index == REG_IMAGE_WIDTH) ||
                                    (i_cfg_index == REG_IMAGE_HEIGHT));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (cfg_we) begin
            case (i_cfg_index)
                REG_IMAGE_WIDTH:  r_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamp dimensions to the supported range
    assign w_eff  = (r_width < DIM_MIN) ? DIM_MIN :
                    (r_width > DIM_MAX_WIDTH) ? DIM_MAX_WIDTH : r_width;
    assign h_eff  = (r_height < DIM_MIN) ? DIM_MIN : r_height;
    assign w_last = w_eff - DIM_W'(1);
    assign h_last = h_eff - DIM_W'(1);

    // ------------------------------------------------------------------
    // input side: position counters
    // ------------------------------------------------------------------
    assign accept = i_valid && !o_stall;
    assign o_stall = r_b_valid && !b_xfer;

    assign pos.r_ge1    = (r_row != '0);
    assign pos.r_ge2    = (r_row > ROW_W'(1));
    assign pos.c_ge1    = (r_col != '0);
    assign pos.c_ge2    = (r_col > COL_W'(1));
    assign pos.last_col = (DIM_W'(r_col) == w_last);
    assign pos.last_row = (r_row == h_last);

    always_comb begin
        n_row = r_row;
        n_col = r_col + COL_W'(1);
        if (DIM_W'(r_col) >= w_last) begin
            n_col = '0;
            n_row = (r_row >= h_last) ? '0 : r_row + ROW_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || cfg_hit) begin
            r_row <= '0;
            r_col <= '0;
        end else if (accept) begin
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    // ------------------------------------------------------------------
    // window stage: holds the word while its line buffer entry is read
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (accept) begin
            r_b_valid <= 1'b1;
        end else if (b_xfer) begin
            r_b_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_b_pix <= {i_pixel_red, i_pixel_green, i_pixel_blue};
            r_b_row <= r_row;
            r_b_col <= r_col;
            r_b_pos <= pos;
        end
    end

    assign b_xfer = r_b_valid && buf_free;

    gb_line_buf u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (accept),
        .i_rd_addr (r_col[ADDR_W-1:0]),
        .o_rd_data (mem_q),
        .i_wr_en   (b_xfer),
        .i_wr_addr (r_b_col[ADDR_W-1:0]),
        .i_wr_data ({mid, r_b_pix})
    );

    assign up  = mem_q[2*PIX_W-1:PIX_W];
    assign mid = mem_q[PIX_W-1:0];

    // window shift: column c-2 then column c-1, each upper/middle/lower
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 6; i++) begin
                r_win[i] <= '0;
            end
        end else if (b_xfer) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= up;
            r_win[4] <= mid;
            r_win[5] <= r_b_pix;
        end
    end

    // ------------------------------------------------------------------
    // blur lanes, one per channel
    // ------------------------------------------------------------------
    for (genvar k = 0; k < CHANNELS; k++) begin : g_lane
        assign taps[k] = {r_b_pix[k*CHAN_W +: CHAN_W],
                          r_win[5][k*CHAN_W +: CHAN_W],
                          r_win[2][k*CHAN_W +: CHAN_W],
                          mid[k*CHAN_W +: CHAN_W],
                          r_win[4][k*CHAN_W +: CHAN_W],
                          r_win[1][k*CHAN_W +: CHAN_W],
                          up[k*CHAN_W +: CHAN_W],
                          r_win[3][k*CHAN_W +: CHAN_W],
                          r_win[0][k*CHAN_W +: CHAN_W]};

        gb_lane u_lane (
            .i_taps (taps[k]),
            .o_blur (blur[k*CHAN_W +: CHAN_W])
        );
    end

    // ------------------------------------------------------------------
    // result candidates in output order, packed into the buffer slots
    // ------------------------------------------------------------------
    always_comb begin
        // delayed pixel: blurred inside, passed through on the border
        cand[0].row = r_b_row - ROW_W'(1);
        cand[0].col = r_b_col - COL_W'(1);
        cand[0].pix = (r_b_pos.r_ge2 && r_b_pos.c_ge2) ? blur : r_win[4];
        cand_v[0]   = r_b_pos.r_ge1 && r_b_pos.c_ge1;
        // right border of the previous row
        cand[1].row = r_b_row - ROW_W'(1);
        cand[1].col = r_b_col;
        cand[1].pix = mid;
        cand_v[1]   = r_b_pos.r_ge1 && r_b_pos.last_col;
        // bottom border
        cand[2].row = r_b_row;
        cand[2].col = r_b_col - COL_W'(1);
        cand[2].pix = r_win[5];
        cand_v[2]   = r_b_pos.last_row && r_b_pos.c_ge1;
        // bottom right corner
        cand[3].row = r_b_row;
        cand[3].col = r_b_col;
        cand[3].pix = r_b_pix;
        cand_v[3]   = r_b_pos.last_row && r_b_pos.last_col;
    end

    always_comb begin
        res_set = '0;
        res_n   = '0;
        for (int i = 0; i < MAX_RES; i++) begin
            if (cand_v[i]) begin
                res_set[res_n[RES_IDX_W-1:0]] = cand[i];
                res_n = res_n + RES_CNT_W'(1);
            end
        end
    end

    // ------------------------------------------------------------------
    // result buffer and output ports
    // ------------------------------------------------------------------
    gb_merge u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (b_xfer),
        .i_set   (res_set),
        .i_count (res_n),
        .o_free  (buf_free),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_res   (out_res),
        .o_last  (o_last_of_run)
    );

    assign o_out_row   = out_res.row;
    assign o_out_col   = out_res.col;
    assign o_out_blue  = out_res.pix[0*CHAN_W +: CHAN_W];
    assign o_out_green = out_res.pix[1*CHAN_W +: CHAN_W];
    assign o_out_red   = out_res.pix[2*CHAN_W +: CHAN_W];

`ifndef NO_ASSERTIONS
    // an accepted word always lands in the window stage
    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_b_valid)
        else $error("accepted word did not reach the window stage");

    // a held window stage keeps its word
    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && !b_xfer |=> r_b_valid && $stable(r_b_col) && $stable(r_b_pix))
        else $error("window stage lost its word while held");

    // a word with results shows them on the next cycle
    a_results_show: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        b_xfer && (res_n != '0) |=> o_valid)
        else $error("loaded results did not appear at the output");

    // the last word of a run empties the buffer unless a new run loads
    a_run_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_of_run && !i_stall && !b_xfer |=> !o_valid)
        else $error("result buffer not empty after the last word of a run");
`endif

endmodule
